>>> rtl/core/eight_bit_accumulator_cpu_top_defines.svh
// Assertion helpers for the accumulator CPU core.
// Both expect clk and rst_n in scope.
`ifndef EIGHT_BIT_ACCUMULATOR_CPU_TOP_DEFINES_SVH
`define EIGHT_BIT_ACCUMULATOR_CPU_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define EBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define EBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/eba_pkg.sv
`default_nettype none

package eba_pkg;

  localparam int unsigned MemDepth = 16;

  typedef enum logic [3:0] {
    OPC_NOP = 4'h0,
    OPC_LDA = 4'h1,
    OPC_ADD = 4'h2,
    OPC_SUB = 4'h3,
    OPC_STA = 4'h4,
    OPC_LDI = 4'h5,
    OPC_JMP = 4'h6,
    OPC_JC  = 4'h7,
    OPC_JZ  = 4'h8,
    OPC_OUT = 4'hE,
    OPC_HLT = 4'hF
  } opcode_t;

  // op field of an input transaction
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EXEC  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [3:0] mem_addr;
    logic [7:0] mem_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_strobe;
    logic       halted;
    logic [3:0] prog_counter;
    logic [7:0] accumulator;
    logic       carry_flag;
    logic       zero_flag;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/eba_if.sv
`default_nettype none

interface eba_in_if;
  import eba_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface eba_out_if;
  import eba_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/core/eight_bit_accumulator_cpu_top.sv
// Channel    Direction  Handshake     Payload
// in_stream  in         valid/ready   op, mem_addr, mem_data
// out_stream out        valid/ready   out_value, out_strobe, halted, prog_counter,
//                                     accumulator, carry_flag, zero_flag
//
// One transaction per cycle unless stalled; its result is registered on the next cycle.
// Throughput is set by the single pass through fetch, operand read and the 8-bit adder.
// in_ready is high whenever the result register is empty or is being emptied that cycle.
// rst_n (synchronous) clears the 16-byte register file and all CPU registers at once.
`default_nettype none

`include "eight_bit_accumulator_cpu_top_defines.svh"

module eight_bit_accumulator_cpu_top (
  input  wire       clk,
  input  wire       rst_n,
  eba_in_if.sink    in_stream,
  eba_out_if.source out_stream
);
  import eba_pkg::*;

  logic [7:0] mem_r [MemDepth];
  logic [3:0] pc_r,    pc_nxt;
  logic [7:0] acc_r,   acc_nxt;
  logic       carry_r, carry_nxt;
  logic       zero_r,  zero_nxt;
  logic [7:0] outv_r,  outv_nxt;
  logic       halt_r,  halt_nxt;
  logic       strobe_nxt;

  logic       mem_we;
  logic [3:0] mem_waddr;
  logic [7:0] mem_wdata;

  logic       res_valid_r;
  out_item_t  res_r;

  logic       in_fire;
  logic [7:0] instr;
  opcode_t    opc;
  logic [3:0] arg;
  logic [7:0] operand;
  logic [8:0] sum;
  logic [3:0] pc_inc;

  assign in_stream.ready  = !res_valid_r || out_stream.ready;
  assign in_fire          = in_stream.valid && in_stream.ready;
  assign out_stream.valid = res_valid_r;
  assign out_stream.payload = res_r;

  assign instr   = mem_r[pc_r];
  assign opc     = opcode_t'(instr[7:4]);
  assign arg     = instr[3:0];
  assign operand = mem_r[arg];
  assign sum     = {1'b0, acc_r} + {1'b0, operand};
  assign pc_inc  = pc_r + 4'd1;

  always_comb begin
    pc_nxt     = pc_r;
    acc_nxt    = acc_r;
    carry_nxt  = carry_r;
    zero_nxt   = zero_r;
    outv_nxt   = outv_r;
    halt_nxt   = halt_r;
    strobe_nxt = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = in_stream.payload.mem_addr;
    mem_wdata  = in_stream.payload.mem_data;

    if (in_stream.payload.op == OP_WRITE) begin
      mem_we = 1'b1;
    end else if (!halt_r) begin
      pc_nxt = pc_inc;
      case (opc)
        OPC_LDA: acc_nxt = operand;
        OPC_ADD: begin
          acc_nxt   = sum[7:0];
          carry_nxt = sum[8];
          zero_nxt  = (sum[7:0] == 8'd0);
        end
        OPC_SUB: begin
          acc_nxt  = acc_r - operand;
          zero_nxt = (acc_r == operand);
        end
        OPC_STA: begin
          mem_we    = 1'b1;
          mem_waddr = arg;
          mem_wdata = acc_r;
        end
        OPC_LDI: acc_nxt = {4'd0, arg};
        OPC_JMP: pc_nxt = arg;
        OPC_JC: begin
          if (carry_r) begin
            pc_nxt    = arg;
            carry_nxt = 1'b0;
          end
        end
        OPC_JZ: begin
          if (zero_r) begin
            pc_nxt   = arg;
            zero_nxt = 1'b0;
          end
        end
        OPC_OUT: begin
          outv_nxt   = acc_r;
          strobe_nxt = 1'b1;
        end
        OPC_HLT: begin
          pc_nxt   = pc_r;
          halt_nxt = 1'b1;
        end
        default: ;  // NOP and undefined opcodes just advance
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MemDepth; i++) begin
        mem_r[i] <= 8'd0;
      end
      pc_r        <= 4'd0;
      acc_r       <= 8'd0;
      carry_r     <= 1'b0;
      zero_r      <= 1'b0;
      outv_r      <= 8'd0;
      halt_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (mem_we) begin
          mem_r[mem_waddr] <= mem_wdata;
        end
        pc_r    <= pc_nxt;
        acc_r   <= acc_nxt;
        carry_r <= carry_nxt;
        zero_r  <= zero_nxt;
        outv_r  <= outv_nxt;
        halt_r  <= halt_nxt;
        res_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r.out_value    <= outv_nxt;
      res_r.out_strobe   <= strobe_nxt;
      res_r.halted       <= halt_nxt;
      res_r.prog_counter <= pc_nxt;
      res_r.accumulator  <= acc_nxt;
      res_r.carry_flag   <= carry_nxt;
      res_r.zero_flag    <= zero_nxt;
    end
  end

  `EBA_ASSERT_NOW(a_no_overwrite, res_valid_r && !out_stream.ready, !in_stream.ready,
                  "result register would be overwritten while stalled")
  `EBA_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r, "halt flag dropped without reset")
  `EBA_ASSERT_NEXT(a_halted_exec_idle,
                   in_fire && in_stream.payload.op == OP_EXEC && halt_r,
                   pc_r == $past(pc_r) && acc_r == $past(acc_r) && !res_r.out_strobe,
                   "execute while halted changed state")
  `EBA_ASSERT_NEXT(a_write_no_strobe, in_fire && in_stream.payload.op == OP_WRITE,
                   !res_r.out_strobe && res_r.prog_counter == pc_r,
                   "memory write transaction disturbed CPU result")

endmodule

`default_nettype wire
